// File: rtl/ini_pkg.sv
package ini_pkg;

    localparam int SectionBytesDef = 16;
    localparam int KeyBytesDef     = 16;

    localparam logic [7:0] ChSemi    = 8'h3B;
    localparam logic [7:0] ChHash    = 8'h23;
    localparam logic [7:0] ChLbrack  = 8'h5B;
    localparam logic [7:0] ChRbrack  = 8'h5D;
    localparam logic [7:0] ChEqual   = 8'h3D;
    localparam logic [7:0] ChNewline = 8'h0A;

    typedef enum logic [2:0] {
        KIND_SECTION = 3'd0,
        KIND_KEY     = 3'd1,
        KIND_VALUE   = 3'd2,
        KIND_REC_END = 3'd3,
        KIND_LINE_ERR = 3'd4,
        KIND_FINAL   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SEC_INCOMPL = 3'd1,
        ST_SEC_LONG    = 3'd2,
        ST_BAD_KEY     = 3'd3,
        ST_NO_SECTION  = 3'd4,
        ST_KEY_LONG    = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_file;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic [2:0] status_code;
        logic       last_of_run;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic       load_in;     // latch input word
        logic       step;        // apply one parse step to latched byte
        logic       eof_close;   // step with newline in place of byte
        logic       clear;       // return parse state to reset
        logic       rep_start;   // begin replay of section then key
        logic       rep_adv;     // advance replay pointer
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       is_eof;
        logic       halted;
        logic       step_emits;  // step produces one single result
        logic       step_replay; // step starts a replay burst
        logic       rep_done;    // replay pointer at last entry (or empty)
        logic       rep_empty;   // nothing to replay
    } dp_sts_t;

    // returns 1 for whitespace bytes that are dropped
    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd9) || (b == 8'd11) || (b == 8'd12) ||
               (b == 8'd13) || (b == 8'd32);
    endfunction

endpackage

// File: rtl/ini_datapath.sv
module ini_datapath
    import ini_pkg::*;
#(
    parameter int SECTION_BYTES = SectionBytesDef,
    parameter int KEY_BYTES     = KeyBytesDef
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       skip_bad_lines,
    input  in_word_t   in_word,
    input  dp_cmd_t    cmd,
    output dp_sts_t    sts,
    output logic [7:0] res_byte,
    output logic [2:0] res_kind,
    output logic [2:0] res_status
);

    localparam int SW = $clog2(SECTION_BYTES + 1);
    localparam int KW = $clog2(KEY_BYTES + 1);
    localparam int SI = (SECTION_BYTES > 2) ? $clog2(SECTION_BYTES - 1) : 1;
    localparam int KI = (KEY_BYTES > 2) ? $clog2(KEY_BYTES - 1) : 1;
    localparam int RW = (SW > KW) ? SW : KW;

    typedef enum logic [7:0] {
        PH_LINE_START  = 8'b0000_0001,
        PH_COMMENT     = 8'b0000_0010,
        PH_SECTION     = 8'b0000_0100,
        PH_AFTER_SEC   = 8'b0000_1000,
        PH_KEY         = 8'b0001_0000,
        PH_VALUE       = 8'b0010_0000,
        PH_VALUE_DONE  = 8'b0100_0000,
        PH_SKIP        = 8'b1000_0000
    } phase_t;

    // stores: two section banks swapped at ']' instead of copying
    logic [7:0] sec_mem0 [SECTION_BYTES-1];
    logic [7:0] sec_mem1 [SECTION_BYTES-1];
    logic [7:0] key_mem  [KEY_BYTES-1];

    phase_t     phase_reg, phase_next;
    logic       bank_reg, bank_next;     // bank holding current section
    logic [SW-1:0] sec_len_reg, sec_len_next;
    logic [SW-1:0] pend_len_reg, pend_len_next;
    logic [KW-1:0] key_len_reg, key_len_next;
    logic [2:0] last_err_reg, last_err_next;
    logic       halted_reg, halted_next;
    logic [7:0] byte_reg;
    logic       eof_reg;

    // replay pointer: first section bytes, then key bytes
    logic          rep_key_reg, rep_key_next;
    logic [RW-1:0] rep_idx_reg, rep_idx_next;

    // registered store reads for the replay
    logic [7:0] sec_rd_reg;
    logic [7:0] key_rd_reg;

    // one-step decode outputs
    logic       emit;
    logic [7:0] e_byte;
    logic [2:0] e_kind;
    logic [2:0] e_status;
    logic       start_rep;
    logic       wr_pend, wr_key;
    logic [7:0] b;
    logic       nl;
    logic       do_step;

    // decode runs ahead of the command; state moves only on a step
    assign do_step = cmd.step || cmd.eof_close;
    assign b  = eof_reg ? ChNewline : byte_reg;
    assign nl = (b == ChNewline);

    // input latch
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            byte_reg <= in_word.text_byte;
            eof_reg  <= in_word.end_of_file;
        end
    end

    // parse step
    always_comb begin
        phase_next    = phase_reg;
        bank_next     = bank_reg;
        sec_len_next  = sec_len_reg;
        pend_len_next = pend_len_reg;
        key_len_next  = key_len_reg;
        last_err_next = last_err_reg;
        halted_next   = halted_reg;
        emit          = 1'b0;
        e_byte        = 8'd0;
        e_kind        = KIND_LINE_ERR;
        e_status      = ST_OK;
        start_rep     = 1'b0;
        wr_pend       = 1'b0;
        wr_key        = 1'b0;
        if (!is_space(b)) begin
            case (phase_reg)
                PH_LINE_START: begin
                    if (nl) begin
                        phase_next = PH_LINE_START;
                    end else if (b == ChSemi || b == ChHash) begin
                        phase_next = PH_COMMENT;
                    end else if (b == ChLbrack) begin
                        pend_len_next = '0;
                        phase_next    = PH_SECTION;
                    end else if (b == ChEqual) begin
                        // key of length zero hits '=' at once
                        key_len_next = '0;
                        phase_next   = PH_KEY;
                        if (sec_len_reg == '0) begin
                            emit = 1'b1; e_status = ST_NO_SECTION;
                            phase_next = PH_SKIP;
                        end else begin
                            start_rep  = 1'b1;
                            phase_next = PH_VALUE;
                        end
                    end else begin
                        wr_key       = 1'b1;
                        key_len_next = KW'(1);
                        phase_next   = PH_KEY;
                    end
                end
                PH_SECTION: begin
                    if (nl) begin
                        emit = 1'b1; e_status = ST_SEC_INCOMPL;
                        phase_next = PH_LINE_START;
                    end else if (b == ChRbrack) begin
                        if (pend_len_reg >= SW'(SECTION_BYTES)) begin
                            emit = 1'b1; e_status = ST_SEC_LONG;
                            phase_next = PH_SKIP;
                        end else begin
                            bank_next    = ~bank_reg;
                            sec_len_next = pend_len_reg;
                            phase_next   = PH_AFTER_SEC;
                        end
                    end else begin
                        wr_pend = (pend_len_reg < SW'(SECTION_BYTES - 1));
                        if (pend_len_reg < SW'(SECTION_BYTES))
                            pend_len_next = pend_len_reg + SW'(1);
                    end
                end
                PH_KEY: begin
                    if (nl) begin
                        emit = 1'b1; e_status = ST_BAD_KEY;
                        phase_next = PH_LINE_START;
                    end else if (b == ChEqual) begin
                        if (sec_len_reg == '0) begin
                            emit = 1'b1; e_status = ST_NO_SECTION;
                            phase_next = PH_SKIP;
                        end else if (key_len_reg >= KW'(KEY_BYTES)) begin
                            emit = 1'b1; e_status = ST_KEY_LONG;
                            phase_next = PH_SKIP;
                        end else begin
                            start_rep  = 1'b1;
                            phase_next = PH_VALUE;
                        end
                    end else begin
                        wr_key = (key_len_reg < KW'(KEY_BYTES - 1));
                        if (key_len_reg < KW'(KEY_BYTES))
                            key_len_next = key_len_reg + KW'(1);
                    end
                end
                PH_VALUE: begin
                    if (nl) begin
                        emit = 1'b1; e_kind = KIND_REC_END;
                        phase_next = PH_LINE_START;
                    end else if (b == ChSemi || b == ChHash) begin
                        phase_next = PH_VALUE_DONE;
                    end else begin
                        emit = 1'b1; e_kind = KIND_VALUE; e_byte = b;
                    end
                end
                default: begin
                    if (nl) begin
                        if (phase_reg == PH_VALUE_DONE) begin
                            emit = 1'b1; e_kind = KIND_REC_END;
                        end
                        phase_next = PH_LINE_START;
                    end
                end
            endcase
            // error bookkeeping
            if (emit && e_kind == KIND_LINE_ERR) begin
                last_err_next = e_status;
                if (!skip_bad_lines) begin
                    halted_next = 1'b1;
                    phase_next  = PH_LINE_START;
                end
            end
        end
    end

    // stores, written one byte per step, read one entry ahead of the replay
    always_ff @(posedge aclk) begin
        if (do_step && wr_pend) begin
            if (bank_reg)
                sec_mem0[SI'(pend_len_reg)] <= b;
            else
                sec_mem1[SI'(pend_len_reg)] <= b;
        end
        if (do_step && wr_key) begin
            key_mem[(phase_reg == PH_KEY) ? KI'(key_len_reg) : KI'(0)] <= b;
        end
        sec_rd_reg <= bank_reg ? sec_mem1[SI'(rep_idx_next)] : sec_mem0[SI'(rep_idx_next)];
        key_rd_reg <= key_mem[KI'(rep_idx_next)];
    end

    // replay pointer
    logic rep_key_empty;
    assign rep_key_empty = (key_len_reg == '0);
    always_comb begin
        rep_key_next = rep_key_reg;
        rep_idx_next = rep_idx_reg;
        if (cmd.rep_start) begin
            rep_key_next = 1'b0;
            rep_idx_next = '0;
        end else if (cmd.rep_adv) begin
            if (!rep_key_reg && (rep_idx_reg + RW'(1) == RW'(sec_len_reg))) begin
                rep_key_next = 1'b1;
                rep_idx_next = '0;
            end else begin
                rep_idx_next = rep_idx_reg + RW'(1);
            end
        end
    end

    assign sts.rep_empty = 1'b0;
    assign sts.rep_done  = rep_key_reg ? (rep_idx_reg + RW'(1) == RW'(key_len_reg))
                         : (rep_key_empty &&
                            (rep_idx_reg + RW'(1) == RW'(sec_len_reg)));

    logic [7:0] rep_byte;
    assign rep_byte = rep_key_reg ? key_rd_reg : sec_rd_reg;

    // result select
    always_comb begin
        if (cmd.rep_adv) begin
            res_byte   = rep_byte;
            res_kind   = rep_key_reg ? KIND_KEY : KIND_SECTION;
            res_status = ST_OK;
        end else if (cmd.clear) begin
            res_byte   = 8'd0;
            res_kind   = KIND_FINAL;
            res_status = last_err_reg;
        end else begin
            res_byte   = e_byte;
            res_kind   = e_kind;
            res_status = e_status;
        end
    end

    assign sts.is_eof      = eof_reg;
    assign sts.halted      = halted_reg;
    assign sts.step_emits  = emit;
    assign sts.step_replay = start_rep;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            phase_reg    <= PH_LINE_START;
            bank_reg     <= 1'b0;
            sec_len_reg  <= '0;
            pend_len_reg <= '0;
            key_len_reg  <= '0;
            last_err_reg <= ST_OK;
            halted_reg   <= 1'b0;
            rep_key_reg  <= 1'b0;
            rep_idx_reg  <= '0;
        end else begin
            if (do_step) begin
                phase_reg    <= phase_next;
                bank_reg     <= bank_next;
                sec_len_reg  <= sec_len_next;
                pend_len_reg <= pend_len_next;
                key_len_reg  <= key_len_next;
                last_err_reg <= last_err_next;
                halted_reg   <= halted_next;
            end
            rep_key_reg  <= rep_key_next;
            rep_idx_reg  <= rep_idx_next;
        end
    end

endmodule

// File: rtl/ini_ctrl.sv
module ini_ctrl
    import ini_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dp_sts_t   sts,
    input  logic      out_free,   // output register can take a word
    output dp_cmd_t   cmd,
    output logic      out_load,
    output logic      out_last
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_STEP   = 5'b00010,
        S_REPLAY = 5'b00100,
        S_CLOSE  = 5'b01000,
        S_FINAL  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        out_last   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid)
                    state_next = S_STEP;
            end
            // one byte (dropped when halted); eof: close the line first unless halted
            S_STEP: begin
                if (sts.is_eof) begin
                    state_next = sts.halted ? S_FINAL : S_CLOSE;
                end else if (sts.halted) begin
                    state_next = S_IDLE;
                end else if (out_free || !sts.step_emits) begin
                    cmd.step  = 1'b1;
                    out_load  = sts.step_emits;
                    out_last  = 1'b1;
                    if (sts.step_replay) begin
                        cmd.rep_start = 1'b1;
                        state_next    = S_REPLAY;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CLOSE: begin
                if (out_free || !sts.step_emits) begin
                    cmd.eof_close = 1'b1;
                    out_load      = sts.step_emits;
                    state_next    = S_FINAL;
                end
            end
            S_REPLAY: begin
                if (out_free) begin
                    cmd.rep_adv = 1'b1;
                    out_load    = 1'b1;
                    out_last    = sts.rep_done;
                    if (sts.rep_done)
                        state_next = S_IDLE;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    cmd.clear  = 1'b1;
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/ini_line_tokenizer.sv
// Channel   Dir  Word        Handshake
// s_        in   in_word_t   s_valid / s_ready
// m_        out  out_word_t  m_valid / m_ready
// cfg_      in   1 bit       cfg_valid / cfg_ready
// An input word is accepted, then given a parse step; a step that
// starts a record at '=' then replays each stored section and key
// byte in turn through the single read port on each store, before the next word is accepted.
// End of file closes the line unless halted, then sends the final status.
// Reset is synchronous, active low; a stalled output holds the
// controller in place.
module ini_line_tokenizer
    import ini_pkg::*;
#(
    parameter int SECTION_BYTES = SectionBytesDef,
    parameter int KEY_BYTES     = KeyBytesDef
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    dp_cmd_t    cmd;
    dp_sts_t    sts;
    logic [7:0] res_byte;
    logic [2:0] res_kind;
    logic [2:0] res_status;
    logic       out_load, out_last, out_free;
    logic       skip_reg;
    logic       m_valid_reg;
    out_word_t  m_data_reg;

    // mode register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn)
            skip_reg <= 1'b1;
        else if (cfg_valid)
            skip_reg <= cfg_data;
    end

    // output register
    assign out_free = !m_valid_reg || m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (out_free)
            m_valid_reg <= out_load;
    end
    always_ff @(posedge aclk) begin
        if (out_load && out_free) begin
            m_data_reg.out_byte    <= res_byte;
            m_data_reg.kind        <= res_kind;
            m_data_reg.status_code <= res_status;
            m_data_reg.last_of_run <= out_last;
        end
    end
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ini_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .sts      (sts),
        .out_free (out_free),
        .cmd      (cmd),
        .out_load (out_load),
        .out_last (out_last)
    );

    ini_datapath #(
        .SECTION_BYTES (SECTION_BYTES),
        .KEY_BYTES     (KEY_BYTES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .skip_bad_lines (skip_reg),
        .in_word        (s_data),
        .cmd            (cmd),
        .sts            (sts),
        .res_byte       (res_byte),
        .res_kind       (res_kind),
        .res_status     (res_status)
    );

endmodule
